// ===== sv/vft_pkg.sv =====
// Shared types and constants for the vibration feature tracker.
`default_nettype none

package vft_pkg;

  // Largest magnitude of one sample, Q7.8.
  localparam logic [14:0] MAG_MAX = 15'h7FFF;

  // Largest value either average can reach, MAG_MAX (Q7.8) scaled to Q7.16.
  localparam logic [22:0] AVG_MAX = 23'd8388352;

  // Reciprocals for the two constant divisions: floor(2^30 / 10) and floor(2^32 / 50).
  localparam logic [26:0] RECIP10 = 27'd107374182;
  localparam logic [26:0] RECIP50 = 27'd85899345;

  // Health band thresholds on the fast average, Q7.16 (2.0, 5.0 and 8.0).
  localparam logic [22:0] HEALTH_TH1 = 23'd131072;
  localparam logic [22:0] HEALTH_TH2 = 23'd327680;
  localparam logic [22:0] HEALTH_TH3 = 23'd524288;

  // Health band values and the alarm limit.
  localparam logic [6:0] HEALTH_GOOD   = 7'd100;
  localparam logic [6:0] HEALTH_FAIR   = 7'd70;
  localparam logic [6:0] HEALTH_POOR   = 7'd40;
  localparam logic [6:0] HEALTH_BAD    = 7'd15;
  localparam logic [6:0] HEALTH_ALARM  = 7'd50;

  // The crest factor is zero while 100 * fast average stays at or below this.
  localparam logic [29:0] CREST_FLOOR = 30'd65536;

  // Bits of the crest factor quotient.
  localparam int unsigned CREST_BITS = 16;

  // Datapath operations issued by the sequencer.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_NUM1,
    OP_MUL1,
    OP_FIX1,
    OP_NUM2,
    OP_MUL2,
    OP_FIX2,
    OP_CREST,
    OP_DIV,
    OP_LOAD
  } vft_op_e;

  // Status reported by the datapath to the sequencer.
  typedef struct packed {
    logic clear_req;
    logic div_needed;
  } vft_stat_t;

  // One result item.
  typedef struct packed {
    logic [14:0] rms_level;
    logic [14:0] peak_level;
    logic [15:0] crest_factor;
    logic [14:0] trend_level;
    logic [6:0]  health_score;
    logic        health_alarm;
    logic        trend_alarm;
  } vft_result_t;

endpackage

`default_nettype wire

// ===== sv/vft_if.sv =====
// Stream interfaces for the sample input and the feature result channels.
`default_nettype none

interface vft_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SAMPLE_BITS-1:0] accel_sample;

  modport source (output valid, output cmd, output accel_sample, input ready);
  modport sink (input valid, input cmd, input accel_sample, output ready);
endinterface

interface vft_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] rms_level;
  logic [14:0] peak_level;
  logic [15:0] crest_factor;
  logic [14:0] trend_level;
  logic [6:0]  health_score;
  logic        health_alarm;
  logic        trend_alarm;

  modport source (
    output valid, output rms_level, output peak_level, output crest_factor,
    output trend_level, output health_score, output health_alarm, output trend_alarm,
    input ready
  );
  modport sink (
    input valid, input rms_level, input peak_level, input crest_factor,
    input trend_level, input health_score, input health_alarm, input trend_alarm,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/vft_ctrl.sv =====
// Sequencer that steps the tracker datapath through one item.
`default_nettype none

module vft_ctrl
  import vft_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire vft_stat_t stat_i,
  output vft_op_e        op_o
);

  localparam int unsigned CNT_W = $clog2(CREST_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CREST_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NUM1,
    S_MUL1,
    S_FIX1,
    S_NUM2,
    S_MUL2,
    S_FIX2,
    S_CREST,
    S_DIV,
    S_LOAD
  } ctrl_state_e;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Operation for the datapath in the current state.
  always_comb begin
    case (state_q)
      S_IDLE:  op_o = accept ? OP_CAPTURE : OP_NONE;
      S_NUM1:  op_o = OP_NUM1;
      S_MUL1:  op_o = OP_MUL1;
      S_FIX1:  op_o = OP_FIX1;
      S_NUM2:  op_o = OP_NUM2;
      S_MUL2:  op_o = OP_MUL2;
      S_FIX2:  op_o = OP_FIX2;
      S_CREST: op_o = OP_CREST;
      S_DIV:   op_o = OP_DIV;
      S_LOAD:  op_o = slot_free ? OP_LOAD : OP_NONE;
      default: op_o = OP_NONE;
    endcase
  end

  // Next state, divide step count and output valid.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = stat_i.clear_req ? S_LOAD : S_NUM1;
        end
      end
      S_NUM1:  state_d = S_MUL1;
      S_MUL1:  state_d = S_FIX1;
      S_FIX1:  state_d = S_NUM2;
      S_NUM2:  state_d = S_MUL2;
      S_MUL2:  state_d = S_FIX2;
      S_FIX2:  state_d = S_CREST;
      S_CREST: begin
        cnt_d   = '0;
        state_d = stat_i.div_needed ? S_DIV : S_LOAD;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  // An accepted item always starts a sequence.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted item did not start a sequence");

  // A load into a free output slot shows a valid result and frees the input.
  a_load_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && slot_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result load did not present a result");

  // The divider runs exactly the quotient width in steps.
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == CNT_LAST) |=> (state_q == S_LOAD))
    else $error("crest division did not end after its last step");
`endif

endmodule

`default_nettype wire

// ===== sv/vft_dp.sv =====
// Datapath of the tracker: averages, peak, crest divider and result register.
`default_nettype none

module vft_dp
  import vft_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vft_op_e                       op_i,
  input  wire logic                          cmd_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output vft_stat_t                          stat_o,
  output vft_result_t                        res_o
);

  localparam int unsigned MAGW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

  // Tracker state.
  logic [22:0] fast_q;
  logic [22:0] slow_q;
  logic [14:0] peak_q;
  logic [15:0] crest_q;

  // Working registers.
  logic [14:0]  mag_q;
  logic [28:0]  num_q;
  logic [55:0]  prod_q;
  logic [22:0]  rem_q;
  vft_result_t  res_q;

  // Saturated magnitude of the incoming sample.
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] neg;
  logic [MAGW-1:0]        mag_ext;
  logic [14:0]            mag;

  assign raw     = $unsigned(sample_i);
  assign neg     = ~raw + 1'b1;
  assign mag_ext = MAGW'(raw[SAMPLE_BITS-1] ? neg : raw);
  assign mag     = (mag_ext > MAGW'(MAG_MAX)) ? MAG_MAX : mag_ext[14:0];

  // Numerators of the two rounded constant divisions.
  logic [28:0] num1;
  logic [28:0] num2;
  logic [14:0] peak_new;

  assign num1     = 29'(fast_q) * 29'd9 + 29'({mag_q, 8'h00}) + 29'd5;
  assign num2     = 29'(slow_q) * 29'd49 + 29'(fast_q) + 29'd25;
  assign peak_new = (mag_q > peak_q) ? mag_q : peak_q;

  // Shared reciprocal multiplier.
  logic [26:0] recip;
  logic [55:0] prod_d;

  assign recip  = (op_i == OP_MUL2) ? RECIP50 : RECIP10;
  assign prod_d = 56'(num_q) * 56'(recip);

  // Quotient estimate and its one-step correction.
  logic [28:0] quo;
  logic [28:0] quo_mul;
  logic [28:0] dconst;
  logic [28:0] rmd;
  logic [28:0] quo_fix;

  always_comb begin
    if (op_i == OP_FIX2) begin
      quo     = 29'(prod_q[55:32]);
      quo_mul = quo * 29'd50;
      dconst  = 29'd50;
    end else begin
      quo     = 29'(prod_q[55:30]);
      quo_mul = quo * 29'd10;
      dconst  = 29'd10;
    end
  end

  assign rmd     = num_q - quo_mul;
  assign quo_fix = (rmd >= dconst) ? quo + 29'd1 : quo;

  // Crest factor range checks and one restoring divide step.
  logic [29:0] fast100;
  logic        crest_nz;
  logic        crest_sat;
  logic [23:0] rem2;
  logic        rem_ge;

  assign fast100   = 30'(fast_q) * 30'd100;
  assign crest_nz  = fast100 > CREST_FLOOR;
  assign crest_sat = 23'(peak_q) >= fast_q;
  assign rem2      = {rem_q, 1'b0};
  assign rem_ge    = rem2 >= 24'(fast_q);

  assign stat_o.clear_req  = cmd_i;
  assign stat_o.div_needed = crest_nz && !crest_sat;

  // Result fields taken from the current state.
  logic [23:0] rms_sum;
  logic [23:0] trend_sum;
  logic [25:0] fast2;
  logic [25:0] slow3;
  vft_result_t res_d;

  assign rms_sum   = 24'(fast_q) + 24'd128;
  assign trend_sum = 24'(slow_q) + 24'd128;
  assign fast2     = 26'(fast_q) * 26'd2;
  assign slow3     = 26'(slow_q) * 26'd3 + 26'd65536;

  always_comb begin
    res_d.rms_level    = (rms_sum[23:8] > 16'(MAG_MAX)) ? MAG_MAX : rms_sum[22:8];
    res_d.trend_level  = (trend_sum[23:8] > 16'(MAG_MAX)) ? MAG_MAX : trend_sum[22:8];
    res_d.peak_level   = peak_q;
    res_d.crest_factor = crest_q;
    if (fast_q < HEALTH_TH1) begin
      res_d.health_score = HEALTH_GOOD;
    end else if (fast_q < HEALTH_TH2) begin
      res_d.health_score = HEALTH_FAIR;
    end else if (fast_q < HEALTH_TH3) begin
      res_d.health_score = HEALTH_POOR;
    end else begin
      res_d.health_score = HEALTH_BAD;
    end
    res_d.health_alarm = res_d.health_score < HEALTH_ALARM;
    res_d.trend_alarm  = fast2 > slow3;
  end

  // Tracker state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q  <= '0;
      slow_q  <= '0;
      peak_q  <= '0;
      crest_q <= '0;
    end else begin
      case (op_i)
        OP_CAPTURE: begin
          if (cmd_i) begin
            peak_q <= '0;
          end
        end
        OP_NUM1: peak_q <= peak_new;
        OP_FIX1: fast_q <= quo_fix[22:0];
        OP_FIX2: slow_q <= quo_fix[22:0];
        OP_CREST: begin
          if (!crest_nz) begin
            crest_q <= '0;
          end else if (crest_sat) begin
            crest_q <= '1;
          end else begin
            crest_q <= '0;
          end
        end
        OP_DIV: crest_q <= {crest_q[CREST_BITS-2:0], rem_ge};
        default: begin
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_CAPTURE: mag_q <= mag;
      OP_NUM1:    num_q <= num1;
      OP_MUL1:    prod_q <= prod_d;
      OP_NUM2:    num_q <= num2;
      OP_MUL2:    prod_q <= prod_d;
      OP_CREST:   rem_q <= 23'(peak_q);
      OP_DIV:     rem_q <= rem_ge ? 23'(rem2 - 24'(fast_q)) : rem2[22:0];
      OP_LOAD:    res_q <= res_d;
      default: begin
      end
    endcase
  end

  assign res_o = res_q;

`ifndef SYNTH
  // Both averages stay within the full-scale magnitude.
  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fast_q <= AVG_MAX) && (slow_q <= AVG_MAX))
    else $error("average left its range");

  // The partial remainder stays below the divisor during division.
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_DIV) |-> (rem_q < fast_q))
    else $error("crest remainder not below the fast average");

  // A clear item zeroes the held peak.
  a_clear_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_CAPTURE && cmd_i) |=> (peak_q == '0))
    else $error("clear item did not zero the held peak");
`endif

endmodule

`default_nettype wire

// ===== sv/vibration_feature_tracker_core.sv =====
// Top level of the vibration feature tracker: sequencer plus datapath.
//
//   channel  modport  handshake      payload
//   in_i     sink     valid/ready    cmd, accel_sample
//   out_o    source   valid/ready    rms_level .. trend_alarm
//
// A sample item passes the capture, the two averages (NUM1, MUL1, FIX1, NUM2, MUL2, FIX2)
// through one shared reciprocal multiplier, the crest check, the bit-serial crest divider
// and one load. With the crest zero or saturated the divider is skipped. A clear item goes
// from acceptance straight to the load. A new item is accepted only once the previous item
// has loaded, and may be accepted while the previous result waits; a result loads only into
// a free output register. Reset is asynchronous, active low, and zeroes the tracker state
// and the sequencer; the working and result registers are not reset.
`default_nettype none

module vibration_feature_tracker_core
  import vft_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vft_in_if.sink     in_i,
  vft_out_if.source  out_o
);

  vft_op_e     op;
  vft_stat_t   stat;
  vft_result_t res;

  // Sequencer.
  vft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .op_o        (op)
  );

  // Datapath.
  vft_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .cmd_i    (in_i.cmd),
    .sample_i (in_i.accel_sample),
    .stat_o   (stat),
    .res_o    (res)
  );

  // Result fields onto the output channel.
  assign out_o.rms_level    = res.rms_level;
  assign out_o.peak_level   = res.peak_level;
  assign out_o.crest_factor = res.crest_factor;
  assign out_o.trend_level  = res.trend_level;
  assign out_o.health_score = res.health_score;
  assign out_o.health_alarm = res.health_alarm;
  assign out_o.trend_alarm  = res.trend_alarm;

endmodule

`default_nettype wire

// ===== tb/vft_feature_monitor.sv =====
// Monitor that predicts every feature result of the tracker and compares it with the output.
`timescale 1ns / 100ps

module vft_feature_monitor
  import vft_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vft_in_if         in_ch,
  vft_out_if        out_ch,
  output int        mismatch_count_o,
  output int        results_due_o
);

  // Tracker state, mirrored at the block's widths.
  logic [22:0] fast_avg_q;
  logic [22:0] slow_avg_q;
  logic [14:0] peak_q;
  logic [15:0] crest_q;

  // Feature results still owed by the block, oldest first.
  vft_result_t features_due[$];
  int          mismatches;

  assign mismatch_count_o = mismatches;

  // Applies one input item to the mirrored state and returns the result it produces.
  function automatic vft_result_t advance_features(input logic clear_peak,
                                                   input logic [15:0] raw);
    logic [16:0] mag;
    logic [14:0] amp;
    logic [63:0] wide;
    vft_result_t res;
    if (clear_peak) begin
      peak_q = '0;
    end else begin
      // Magnitude of the sample; the most negative value saturates.
      mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      amp = (mag > 17'd32767) ? MAG_MAX : mag[14:0];
      wide = (64'd9 * fast_avg_q + 64'd256 * amp + 64'd5) / 64'd10;
      fast_avg_q = wide[22:0];
      if (amp > peak_q) begin
        peak_q = amp;
      end
      // Crest factor is held at zero while the fast average is tiny.
      if (64'd100 * fast_avg_q > 64'd65536) begin
        wide = (64'(peak_q) << 16) / 64'(fast_avg_q);
        crest_q = (wide > 64'd65535) ? 16'hFFFF : wide[15:0];
      end else begin
        crest_q = '0;
      end
      wide = (64'd49 * slow_avg_q + 64'(fast_avg_q) + 64'd25) / 64'd50;
      slow_avg_q = wide[22:0];
    end

    // Rounded Q7.8 views of both averages.
    wide = (64'(fast_avg_q) + 64'd128) >> 8;
    res.rms_level = (wide > 64'd32767) ? MAG_MAX : wide[14:0];
    wide = (64'(slow_avg_q) + 64'd128) >> 8;
    res.trend_level = (wide > 64'd32767) ? MAG_MAX : wide[14:0];
    res.peak_level = peak_q;
    res.crest_factor = crest_q;

    // Health band from the fast average.
    if (fast_avg_q < HEALTH_TH1) begin
      res.health_score = HEALTH_GOOD;
    end else if (fast_avg_q < HEALTH_TH2) begin
      res.health_score = HEALTH_FAIR;
    end else if (fast_avg_q < HEALTH_TH3) begin
      res.health_score = HEALTH_POOR;
    end else begin
      res.health_score = HEALTH_BAD;
    end
    res.health_alarm = (res.health_score < HEALTH_ALARM);
    res.trend_alarm = (64'd2 * fast_avg_q > 64'd3 * slow_avg_q + 64'd65536);
    return res;
  endfunction

  // Results are checked before new items are predicted, so an edge that moves both stays ordered.
  always @(posedge clk_i or negedge rst_ni) begin
    vft_result_t seen;
    vft_result_t want;
    if (!rst_ni) begin
      fast_avg_q = '0;
      slow_avg_q = '0;
      peak_q = '0;
      crest_q = '0;
      features_due.delete();
      mismatches = 0;
      results_due_o <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = '{rms_level: out_ch.rms_level, peak_level: out_ch.peak_level,
                 crest_factor: out_ch.crest_factor, trend_level: out_ch.trend_level,
                 health_score: out_ch.health_score, health_alarm: out_ch.health_alarm,
                 trend_alarm: out_ch.trend_alarm};
        if (features_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("vft mismatch at %0t: result item with none expected, rms %0d peak %0d",
                     $realtime, seen.rms_level, seen.peak_level);
          end
          mismatches++;
        end else begin
          want = features_due.pop_front();
          if (seen !== want) begin
            if (mismatches < 10) begin
              $display("vft mismatch at %0t: expected rms %0d peak %0d crest %0d trend %0d",
                       $realtime, want.rms_level, want.peak_level, want.crest_factor,
                       want.trend_level, " health %0d alarm %0b trend_alarm %0b",
                       want.health_score, want.health_alarm, want.trend_alarm);
              $display("    actual rms %0d peak %0d crest %0d trend %0d",
                       seen.rms_level, seen.peak_level, seen.crest_factor, seen.trend_level,
                       " health %0d alarm %0b trend_alarm %0b",
                       seen.health_score, seen.health_alarm, seen.trend_alarm);
            end
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        features_due.push_back(advance_features(in_ch.cmd, in_ch.accel_sample));
      end
      results_due_o <= features_due.size();
    end
  end

endmodule

// ===== tb/tb_vibration_feature_tracker_core.sv =====
// Testbench top: drives samples and clear commands into the tracker and reports the verdict.
`timescale 1ns / 100ps

module tb_vibration_feature_tracker_core;
  import vft_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // Input command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Amplitude classes for runs of random samples.
  typedef enum int unsigned {
    LVL_QUIET,
    LVL_SMALL,
    LVL_MEDIUM,
    LVL_LARGE,
    LVL_FULL,
    LVL_EDGE
  } level_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   tx_idle_pct = 20;
  int   rx_idle_pct = 47;
  int   stall_cycles = 0;
  int   mismatch_count;
  int   results_due;

  vft_in_if #(.SAMPLE_BITS(16)) in_ch ();
  vft_out_if out_ch ();

  always #4 clk_i = ~clk_i;

  vibration_feature_tracker_core #(
    .SAMPLE_BITS(16)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  vft_feature_monitor monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count_o(mismatch_count),
    .results_due_o   (results_due)
  );

  // Result side stalls at random in the current share of cycles.
  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[vibration_feature_tracker_core] ERROR");
      $finish;
    end
  end

  // Draws one sample of the given amplitude class with a random sign.
  function automatic logic [15:0] draw_sample(input level_e level);
    int unsigned mag;
    logic [15:0] s;
    case (level)
      LVL_QUIET:  mag = $urandom_range(3);
      LVL_SMALL:  mag = $urandom_range(255);
      LVL_MEDIUM: mag = $urandom_range(2047);
      LVL_LARGE:  mag = $urandom_range(8191);
      LVL_FULL:   mag = $urandom_range(32767);
      default:    mag = $urandom_range(32767, 32000);
    endcase
    s = mag[15:0];
    if ($urandom_range(1) == 1) begin
      s = -s;
    end
    if (level == LVL_EDGE && $urandom_range(7) == 0) begin
      s = 16'h8000;
    end
    return s;
  endfunction

  // Offers one item after a random gap and waits until the block takes it.
  task automatic send_item(input logic cmd, input logic [15:0] sample);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.accel_sample <= sample;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Holds the input idle until every owed result has come out.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  // Runs of samples at one amplitude, with clears and lone full-range spikes mixed in.
  task automatic run_random(input int unsigned count);
    level_e      level = LVL_QUIET;
    int unsigned left = 0;
    int unsigned sent = 0;
    while (sent < count) begin
      if (left == 0) begin
        level = level_e'($urandom_range(LVL_EDGE));
        left = $urandom_range(80, 10);
      end
      left--;
      if ($urandom_range(99) < 4) begin
        send_item(CMD_CLEAR, 16'($urandom));
      end else if ($urandom_range(99) < 2) begin
        send_item(CMD_SAMPLE, 16'($urandom));
      end else begin
        send_item(CMD_SAMPLE, draw_sample(level));
      end
      sent++;
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SAMPLE;
    in_ch.accel_sample = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset state, tiny and extreme samples, health bands, clears.
    send_item(CMD_CLEAR, 16'h7FFF);
    send_item(CMD_SAMPLE, 16'h0000);
    send_item(CMD_SAMPLE, 16'h0001);
    send_item(CMD_SAMPLE, 16'hFFFF);
    repeat (5) send_item(CMD_SAMPLE, 16'h1400);
    send_item(CMD_SAMPLE, 16'h8000);
    send_item(CMD_SAMPLE, 16'h8001);
    send_item(CMD_SAMPLE, 16'h7FFF);
    send_item(CMD_CLEAR, 16'h8000);
    send_item(CMD_SAMPLE, 16'h0000);
    send_item(CMD_SAMPLE, 16'h0100);
    send_item(CMD_CLEAR, 16'h0000);
    send_item(CMD_CLEAR, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'h5555);
    send_item(CMD_SAMPLE, 16'hAAAA);
    repeat (3) send_item(CMD_SAMPLE, 16'h0000);
    run_random(520);
    hold_until_drained();

    // Sender stalls more than the receiver.
    tx_idle_pct = 47;
    rx_idle_pct = 20;
    run_random(520);
    hold_until_drained();

    // Both sides at full rate.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(510);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && results_due == 0) begin
      $display("[vibration_feature_tracker_core] OK");
    end else begin
      $display("[vibration_feature_tracker_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vft_pkg.sv
sv/vft_if.sv
sv/vft_ctrl.sv
sv/vft_dp.sv
sv/vibration_feature_tracker_core.sv
tb/vft_feature_monitor.sv
tb/tb_vibration_feature_tracker_core.sv
